// ----- hdl/multichannel_valve_timer_core_macros.svh -----
// Assertion helpers shared by the valve timer core.
`ifndef MULTICHANNEL_VALVE_TIMER_CORE_MACROS_SVH
`define MULTICHANNEL_VALVE_TIMER_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define MVT_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("valve timer assertion failed (same cycle)");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define MVT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("valve timer assertion failed (next cycle)");

`endif

// ----- hdl/mvt_pkg.sv -----
`timescale 1ns / 1ps

package mvt_pkg;

   localparam int CMD_W   = 3;
   localparam int VALVE_W = 2;
   localparam int TIME_W  = 17;
   localparam int MODE_W  = 2;
   localparam int MASK_W  = 4;

   // Number of channels a valve field can address.
   localparam int VALVE_SPAN = 2 ** VALVE_W;

   localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ON_PERM  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ON_TIMED = 3'd2;
   localparam logic [CMD_W-1:0] CMD_OFF_ONE  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_OFF_ALL  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd5;

   localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PERM  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TIMED = 2'd2;

   localparam logic [TIME_W-1:0] RUNTIME_CAP_RESET = 17'd3600;

   // Broadcast from the core to every channel slice.
   typedef struct packed {
      logic              advance;
      logic [CMD_W-1:0]  cmd;
      logic [TIME_W-1:0] duration;
      logic [TIME_W-1:0] runtime_cap;
   } mvt_chan_ctrl_type;

   // State of one channel after the current transaction, plus tick events.
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [TIME_W-1:0] remaining;
      logic [TIME_W-1:0] elapsed;
      logic              forced;
      logic              expired;
   } mvt_chan_status_type;

endpackage

// ----- hdl/mvt_req_if.sv -----
`timescale 1ns / 1ps

interface mvt_req_if;
   logic                         valid;
   logic                         ready;
   logic [mvt_pkg::CMD_W-1:0]    cmd;
   logic [mvt_pkg::VALVE_W-1:0]  valve;
   logic [mvt_pkg::TIME_W-1:0]   duration;

   modport source (output valid, output cmd, output valve, output duration, input ready);
   modport sink   (input valid, input cmd, input valve, input duration, output ready);
endinterface

// ----- hdl/mvt_rsp_if.sv -----
`timescale 1ns / 1ps

interface mvt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [mvt_pkg::MASK_W-1:0]  drive_mask;
   logic [mvt_pkg::MASK_W-1:0]  forced_mask;
   logic [mvt_pkg::MASK_W-1:0]  expired_mask;
   logic [mvt_pkg::MODE_W-1:0]  query_mode;
   logic [mvt_pkg::TIME_W-1:0]  query_remaining;
   logic [mvt_pkg::TIME_W-1:0]  query_runtime;

   modport source (output valid, output drive_mask, output forced_mask, output expired_mask,
                   output query_mode, output query_remaining, output query_runtime,
                   input ready);
   modport sink   (input valid, input drive_mask, input forced_mask, input expired_mask,
                   input query_mode, input query_remaining, input query_runtime,
                   output ready);
endinterface

// ----- hdl/mvt_csr_if.sv -----
`timescale 1ns / 1ps

interface mvt_csr_if;
   logic                       valid;
   logic                       ready;
   logic [mvt_pkg::TIME_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/mvt_channel.sv -----
`timescale 1ns / 1ps

module mvt_channel (
   input  logic                         clock,
   input  logic                         reset,
   input  mvt_pkg::mvt_chan_ctrl_type   ctrl,
   input  logic                         sel,
   output mvt_pkg::mvt_chan_status_type status
);

   logic [mvt_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [mvt_pkg::TIME_W-1:0] remaining_ff, remaining_in;
   logic [mvt_pkg::TIME_W-1:0] elapsed_ff, elapsed_in;

   always_comb begin
      logic [mvt_pkg::TIME_W-1:0] elapsed_inc;
      logic [mvt_pkg::TIME_W-1:0] remaining_dec;
      elapsed_inc   = elapsed_ff + 17'd1;
      remaining_dec = (remaining_ff != '0) ? remaining_ff - 17'd1 : remaining_ff;
      mode_in        = mode_ff;
      remaining_in   = remaining_ff;
      elapsed_in     = elapsed_ff;
      status.forced  = 1'b0;
      status.expired = 1'b0;
      unique case (ctrl.cmd)
         mvt_pkg::CMD_TICK: begin
            // Check the runtime limit before the countdown.
            priority if (mode_ff == mvt_pkg::MODE_OFF) begin
            end else if (elapsed_inc >= ctrl.runtime_cap) begin
               mode_in       = mvt_pkg::MODE_OFF;
               remaining_in  = '0;
               elapsed_in    = '0;
               status.forced = 1'b1;
            end else if (mode_ff == mvt_pkg::MODE_TIMED && remaining_dec == '0) begin
               mode_in        = mvt_pkg::MODE_OFF;
               remaining_in   = '0;
               elapsed_in     = '0;
               status.expired = 1'b1;
            end else if (mode_ff == mvt_pkg::MODE_TIMED) begin
               remaining_in = remaining_dec;
               elapsed_in   = elapsed_inc;
            end else begin
               elapsed_in = elapsed_inc;
            end
         end
         mvt_pkg::CMD_ON_PERM: begin
            if (sel) begin
               mode_in      = mvt_pkg::MODE_PERM;
               remaining_in = '0;
               elapsed_in   = '0;
            end
         end
         mvt_pkg::CMD_ON_TIMED: begin
            if (sel) begin
               mode_in      = (ctrl.duration == '0) ? mvt_pkg::MODE_OFF : mvt_pkg::MODE_TIMED;
               remaining_in = ctrl.duration;
               elapsed_in   = '0;
            end
         end
         mvt_pkg::CMD_OFF_ONE: begin
            if (sel) begin
               mode_in      = mvt_pkg::MODE_OFF;
               remaining_in = '0;
               elapsed_in   = '0;
            end
         end
         mvt_pkg::CMD_OFF_ALL: begin
            mode_in      = mvt_pkg::MODE_OFF;
            remaining_in = '0;
            elapsed_in   = '0;
         end
         default: begin
            // Query and unused codes: hold.
         end
      endcase
      status.mode      = mode_in;
      status.remaining = remaining_in;
      status.elapsed   = elapsed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= mvt_pkg::MODE_OFF;
         remaining_ff <= '0;
         elapsed_ff   <= '0;
      end else if (ctrl.advance) begin
         mode_ff      <= mode_in;
         remaining_ff <= remaining_in;
         elapsed_ff   <= elapsed_in;
      end
   end

endmodule

// ----- hdl/multichannel_valve_timer_core.sv -----
`timescale 1ns / 1ps
// Multichannel valve timer core.
//
// req_bus carries one command transaction: cmd (tick, on permanent, on timed,
// off one, off all, query), valve index and duration in seconds. Every request
// transaction produces exactly one rsp_bus transaction holding the drive mask
// after the command, the channels forced off or expired on a tick, and the
// mode, remaining time and runtime of the addressed channel.
// csr_bus writes the runtime cap; it is always ready and must be written only
// while no command is in flight.
//
// A request accepted into the request register passes the per-channel update
// logic into the response register, which offers it on rsp_bus. Throughput:
// one transaction per cycle while rsp_bus is not stalled, set by the single pass
// of the per-channel update logic between the request and response registers.
// Reset (synchronous, active high) turns every channel off, clears all counters
// and loads the runtime cap with 3600. When the receiver stalls, the response
// register holds; one more request is still taken into the request register,
// after which req_bus.ready drops until the response is taken.

`include "multichannel_valve_timer_core_macros.svh"

module multichannel_valve_timer_core #(
   parameter int CHANNELS = 4
) (
   input  logic      clock,
   input  logic      reset,
   mvt_req_if.sink   req_bus,
   mvt_rsp_if.source rsp_bus,
   mvt_csr_if.sink   csr_bus
);

   // Request register.
   logic                          in_valid_ff, in_valid_in;
   logic [mvt_pkg::CMD_W-1:0]     in_cmd_ff;
   logic [mvt_pkg::VALVE_W-1:0]   in_valve_ff;
   logic [mvt_pkg::TIME_W-1:0]    in_dur_ff;

   // Response register.
   logic                          out_valid_ff, out_valid_in;
   logic [mvt_pkg::MASK_W-1:0]    drive_ff, forced_ff, expired_ff;
   logic [mvt_pkg::MODE_W-1:0]    qmode_ff, qmode_in;
   logic [mvt_pkg::TIME_W-1:0]    qrem_ff, qrem_in;
   logic [mvt_pkg::TIME_W-1:0]    qrun_ff, qrun_in;

   logic [mvt_pkg::TIME_W-1:0]    runtime_cap_ff;

   logic                          advance;
   logic                          req_fire;
   logic [CHANNELS-1:0]           sel;
   mvt_pkg::mvt_chan_ctrl_type    ctrl;
   mvt_pkg::mvt_chan_status_type  status [CHANNELS];
   logic [mvt_pkg::MASK_W-1:0]    drive_in, forced_in, expired_in;

   // Check terms.
   logic                          adv_not_tick;
   logic                          adv_off_all;
   logic [mvt_pkg::MASK_W-1:0]    off_and_driven;

   // Move the held request into the response register when that one is free
   // or being drained this cycle.
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_fire = req_bus.valid && req_bus.ready;

   assign req_bus.ready = !in_valid_ff || advance;
   assign csr_bus.ready = 1'b1;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the request payload.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cmd_ff   <= req_bus.cmd;
         in_valve_ff <= req_bus.valve;
         in_dur_ff   <= req_bus.duration;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         runtime_cap_ff <= mvt_pkg::RUNTIME_CAP_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         runtime_cap_ff <= csr_bus.data;
      end
   end

   assign ctrl.advance     = advance;
   assign ctrl.cmd         = in_cmd_ff;
   assign ctrl.duration    = in_dur_ff;
   assign ctrl.runtime_cap = runtime_cap_ff;

   // One slice per channel; a channel beyond the valve field's reach is
   // never addressed.
   for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
      if (i < mvt_pkg::VALVE_SPAN) begin : g_addr
         assign sel[i] = (in_valve_ff == mvt_pkg::VALVE_W'(i));
      end else begin : g_noaddr
         assign sel[i] = 1'b0;
      end
      mvt_channel u_channel (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (ctrl),
         .sel    (sel[i]),
         .status (status[i])
      );
   end

   // Only the low channels show in the masks; missing channels read as zero.
   for (genvar b = 0; b < mvt_pkg::MASK_W; b++) begin : g_mask
      if (b < CHANNELS) begin : g_have
         assign drive_in[b]   = (status[b].mode != mvt_pkg::MODE_OFF);
         assign forced_in[b]  = status[b].forced;
         assign expired_in[b] = status[b].expired;
      end else begin : g_none
         assign drive_in[b]   = 1'b0;
         assign forced_in[b]  = 1'b0;
         assign expired_in[b] = 1'b0;
      end
   end

   // Select the addressed channel's next state; an index with no channel
   // reports zeros.
   always_comb begin
      qmode_in = '0;
      qrem_in  = '0;
      qrun_in  = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (sel[i]) begin
            qmode_in = qmode_in | status[i].mode;
            qrun_in  = qrun_in | status[i].elapsed;
            if (status[i].mode == mvt_pkg::MODE_TIMED) begin
               qrem_in = qrem_in | status[i].remaining;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         drive_ff   <= drive_in;
         forced_ff  <= forced_in;
         expired_ff <= expired_in;
         qmode_ff   <= qmode_in;
         qrem_ff    <= qrem_in;
         qrun_ff    <= qrun_in;
      end
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.drive_mask      = drive_ff;
   assign rsp_bus.forced_mask     = forced_ff;
   assign rsp_bus.expired_mask    = expired_ff;
   assign rsp_bus.query_mode      = qmode_ff;
   assign rsp_bus.query_remaining = qrem_ff;
   assign rsp_bus.query_runtime   = qrun_ff;

   assign adv_not_tick   = advance && (in_cmd_ff != mvt_pkg::CMD_TICK);
   assign adv_off_all    = advance && (in_cmd_ff == mvt_pkg::CMD_OFF_ALL);
   assign off_and_driven = (forced_ff | expired_ff) & drive_ff;

   // A held request that moves forward always lands as a valid response.
   `MVT_ASSERT_NEXT(a_advance_loads, clock, reset, advance, out_valid_ff)
   // Only a tick may report forced or expired channels.
   `MVT_ASSERT_NEXT(a_masks_tick_only, clock, reset, adv_not_tick, (forced_ff | expired_ff) == '0)
   // Switching all off leaves nothing driven.
   `MVT_ASSERT_NEXT(a_off_all_clears, clock, reset, adv_off_all, drive_ff == '0)
   // A channel turned off on a tick is not driven afterward.
   `MVT_ASSERT_SAME(a_off_not_driven, clock, reset, out_valid_ff, off_and_driven == '0)

endmodule
